[sv/pacrt_pkg.sv]
// Shared types and constants for the per-address connection rate table.
`timescale 1ns / 1ps
package pacrt_pkg;

	localparam int TABLE_SIZE_DEF  = 64;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int OUT_COUNT_W     = 16;
	localparam logic [15:0] LEAK_RESET = 16'd1000;

	typedef enum logic [1:0] {
		ACT_RECORD = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_SWEEP  = 2'd2,
		ACT_NONE   = 2'd3
	} act_e_t;

	typedef struct packed {
		logic start;
		logic rd;
		logic note_free;
		logic idx_inc;
		logic hit_inc;
		logic div_start;
		logic decay;
		logic fill;
		logic emit;
	} cmd_t;

	typedef struct packed {
		act_e_t act;
		logic   valid_here;
		logic   match_here;
		logic   last;
		logic   div_busy;
		logic   out_free;
	} sts_t;

endpackage

[sv/pacrt_ctrl.sv]
// Sequencer for scan, decay and result hand-off of the rate table.
`timescale 1ns / 1ps
module pacrt_ctrl
	import pacrt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_READ  = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_APPLY = 7'b0010000,
		S_FILL  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				unique case (sts.act)
					ACT_RECORD: begin
						if (sts.match_here) begin
							cmd.hit_inc = 1'b1;
							state_d     = S_DONE;
						end else begin
							cmd.note_free = 1'b1;
							if (sts.last) begin
								state_d = S_FILL;
							end else begin
								cmd.idx_inc = 1'b1;
								state_d     = S_READ;
							end
						end
					end
					ACT_QUERY: begin
						if (sts.match_here) begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end else if (sts.last) begin
							state_d = S_DONE;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_READ;
						end
					end
					ACT_SWEEP: begin
						if (sts.valid_here) begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end else if (sts.last) begin
							state_d = S_DONE;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_READ;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_DIV: begin
				if (!sts.div_busy) state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.decay = 1'b1;
				if (sts.act == ACT_SWEEP && !sts.last) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_READ;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

[sv/pacrt_dp.sv]
// Entry store, valid bits, serial divider, result and output registers.
`timescale 1ns / 1ps
module pacrt_dp
	import pacrt_pkg::*;
#(
	parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_data,
	input  logic [1:0]             action,
	input  logic [31:0]            ip_address,
	input  logic [31:0]            now_ms,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [OUT_COUNT_W-1:0] count,
	output logic                   found,
	output logic                   table_full,
	input  cmd_t                   cmd,
	output sts_t                   sts
);

	localparam int IW    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CW    = COUNT_WIDTH;
	localparam int WW    = 64 + CW;
	localparam int EXT_W = (CW > OUT_COUNT_W) ? CW : OUT_COUNT_W;

	logic [15:0]           leak_q;
	act_e_t                act_q;
	logic [31:0]           key_q;
	logic [31:0]           now_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         free_idx_q;
	logic                  have_free_q;
	logic [TABLE_SIZE-1:0] valid_q;
	logic [WW-1:0]         mem [TABLE_SIZE];
	logic [WW-1:0]         rdata_q;
	logic [CW-1:0]         res_cnt_q;
	logic                  res_found_q;
	logic                  res_full_q;
	logic                  out_valid_q;
	logic [OUT_COUNT_W-1:0] out_cnt_q;
	logic                  out_found_q;
	logic                  out_full_q;
	logic [31:0]           quo_q;
	logic [15:0]           rem_q;
	logic [4:0]            div_cnt_q;
	logic                  div_busy_q;

	logic [31:0]   r_addr, r_stamp, elapsed;
	logic [CW-1:0] r_cnt, inc_cnt, dec_cnt;
	logic [15:0]   period;
	logic [16:0]   trial;
	logic          take;
	logic          empties;
	logic          we;
	logic [IW-1:0] waddr;
	logic [WW-1:0] wdata;
	logic [EXT_W-1:0] cnt_ext;
	logic [OUT_COUNT_W-1:0] cnt_sat;

	assign r_addr  = rdata_q[WW-1 -: 32];
	assign r_cnt   = rdata_q[CW+31:32];
	assign r_stamp = rdata_q[31:0];
	assign elapsed = now_q - r_stamp;
	assign period  = (leak_q == 16'd0) ? 16'd1 : leak_q;
	assign trial   = {rem_q, quo_q[31]};
	assign take    = (trial >= {1'b0, period});
	assign inc_cnt = (r_cnt == {CW{1'b1}}) ? r_cnt : r_cnt + CW'(1);
	assign empties = (quo_q >= 32'(r_cnt));
	assign dec_cnt = r_cnt - CW'(quo_q);

	assign cnt_ext = EXT_W'(res_cnt_q);
	assign cnt_sat = (cnt_ext > EXT_W'({OUT_COUNT_W{1'b1}})) ? {OUT_COUNT_W{1'b1}}
	                                                          : cnt_ext[OUT_COUNT_W-1:0];

	assign sts.act        = act_q;
	assign sts.valid_here = valid_q[idx_q];
	assign sts.match_here = valid_q[idx_q] && (r_addr == key_q);
	assign sts.last       = (idx_q == IW'(TABLE_SIZE - 1));
	assign sts.div_busy   = div_busy_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign count      = out_cnt_q;
	assign found      = out_found_q;
	assign table_full = out_full_q;

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata_q;
		if (cmd.hit_inc) begin
			we    = 1'b1;
			wdata = {r_addr, inc_cnt, r_stamp};
		end else if (cmd.decay && !empties) begin
			we    = 1'b1;
			wdata = {r_addr, dec_cnt, now_q - 32'(rem_q)};
		end else if (cmd.fill && have_free_q) begin
			we    = 1'b1;
			waddr = free_idx_q;
			wdata = {key_q, CW'(1), now_q};
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.rd) rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leak_q      <= LEAK_RESET;
			valid_q     <= '0;
			have_free_q <= 1'b0;
			div_busy_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) leak_q <= cfg_data;
			if (cmd.start) have_free_q <= 1'b0;
			else if (cmd.note_free && !valid_q[idx_q] && !have_free_q) have_free_q <= 1'b1;
			if (cmd.decay && empties) valid_q[idx_q] <= 1'b0;
			else if (cmd.fill && have_free_q) valid_q[free_idx_q] <= 1'b1;
			if (cmd.div_start) div_busy_q <= 1'b1;
			else if (div_busy_q && div_cnt_q == 5'd0) div_busy_q <= 1'b0;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q       <= act_e_t'(action);
			key_q       <= ip_address;
			now_q       <= now_ms;
			idx_q       <= '0;
			res_cnt_q   <= '0;
			res_found_q <= 1'b0;
			res_full_q  <= 1'b0;
		end
		if (cmd.idx_inc) idx_q <= idx_q + IW'(1);
		if (cmd.note_free && !valid_q[idx_q] && !have_free_q) free_idx_q <= idx_q;
		if (cmd.hit_inc) begin
			res_cnt_q   <= inc_cnt;
			res_found_q <= 1'b1;
		end
		if (cmd.decay && act_q == ACT_QUERY) begin
			res_cnt_q   <= empties ? '0 : dec_cnt;
			res_found_q <= 1'b1;
		end
		if (cmd.fill) begin
			if (have_free_q) res_cnt_q <= CW'(1);
			else res_full_q <= 1'b1;
		end
		if (cmd.div_start) begin
			quo_q     <= elapsed;
			rem_q     <= '0;
			div_cnt_q <= 5'd31;
		end else if (div_busy_q) begin
			rem_q     <= take ? 16'(trial - {1'b0, period}) : trial[15:0];
			quo_q     <= {quo_q[30:0], take};
			div_cnt_q <= div_cnt_q - 5'd1;
		end
		if (cmd.emit) begin
			out_cnt_q   <= cnt_sat;
			out_found_q <= res_found_q;
			out_full_q  <= res_full_q;
		end
	end

endmodule

[sv/per_address_connection_rate_table.sv]
// Top level of the per-address connection rate table.
// Record/query: a read and a check per entry scanned (up to TABLE_SIZE); a query hit decays.
// Sweep: scans all entries; each live entry runs the 32-step serial divider and a decay.
// Result emitted when scan ends and output is free; one transaction in flight at a time.
// Reset clears valid bits and control at once; leak period resets to 1000 ms.
`timescale 1ns / 1ps
module per_address_connection_rate_table
	import pacrt_pkg::*;
#(
	parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [15:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             action,
	input  logic [31:0]            ip_address,
	input  logic [31:0]            now_ms,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUT_COUNT_W-1:0] count,
	output logic                   found,
	output logic                   table_full
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	pacrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pacrt_dp #(
		.TABLE_SIZE  (TABLE_SIZE),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.action     (action),
		.ip_address (ip_address),
		.now_ms     (now_ms),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.count      (count),
		.found      (found),
		.table_full (table_full),
		.cmd        (cmd),
		.sts        (sts)
	);

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free) else $error("emit into occupied output");
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy) else $error("divider did not start");
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> (!found && count == '0))
		else $error("table_full with count or found");
`endif

endmodule
